[hdl/lazy_segment_tree_range_add_sum_unit_defines.svh]
// Assertion macros for the lazy segment tree range add/sum unit.
// Used by the top level; expects clk and arst_n in the scope of use.
`ifndef LAZY_SEGMENT_TREE_RANGE_ADD_SUM_UNIT_DEFINES_SVH
`define LAZY_SEGMENT_TREE_RANGE_ADD_SUM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LST_ASSERT_IMP(lbl, ante, cons, msg)
`define LST_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/lst_pkg.sv]
// Shared types and constants for the lazy segment tree range add/sum unit.
// No dependencies; imported by every module of the unit.
package lst_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int NODE_W = 11;
	localparam int NODE_COUNT = 2 * MAX_ELEMENTS;
	localparam int STK_DEPTH = 10;
	localparam int SP_W = 4;
	localparam int CQ_DEPTH = 4;
	localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd1024;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_SUM = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	typedef enum logic [1:0] {
		K_LOAD = 2'd0,
		K_ADD  = 2'd1,
		K_SUM  = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  last_index;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] range_sum;
		logic               range_error;
	} rsp_t;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] f;
		logic [IDX_W-1:0] t;
		logic [31:0]      v;
		logic [IDX_W-1:0] last;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic              phase;
		logic [31:0]       sum_l;
	} frame_t;
endpackage

[hdl/lst_front.sv]
// Front part: element count register, request check and command queue.
// Depends on lst_pkg.
module lst_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lst_pkg::req_t       req,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata,
	input  logic                hold,
	output logic                cmd_valid,
	output lst_pkg::cmd_t       cmd,
	input  logic                cmd_ready
);
	import lst_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n;
	logic [IDX_W-1:0] last;
	cmd_t             cls;
	cmd_t             q_q [CQ_DEPTH];
	logic [2:0]       fill_q;
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		if (count_q == '0) begin
			n = 11'd1;
		end else if (count_q > COUNT_MAX) begin
			n = COUNT_MAX;
		end else begin
			n = count_q;
		end
		last = IDX_W'(n - 11'd1);
		cls.f = req.first_index;
		cls.t = req.last_index;
		cls.v = req.operand_value;
		cls.last = last;
		case (req.mode)
			MODE_LOAD: begin
				cls.t = req.first_index;
				cls.kind = ({1'b0, req.first_index} >= n) ? K_ERR : K_LOAD;
			end
			MODE_ADD, MODE_SUM: begin
				if (req.first_index > req.last_index || {1'b0, req.last_index} >= n) begin
					cls.kind = K_ERR;
				end else begin
					cls.kind = (req.mode == MODE_ADD) ? K_ADD : K_SUM;
				end
			end
			default: cls.kind = K_ERR;
		endcase
	end

	assign full = (fill_q == 3'(CQ_DEPTH)) || hold;
	assign do_push = push && !full;
	assign cmd_valid = (fill_q != '0);
	assign do_pop = cmd_valid && cmd_ready;
	assign cmd = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			fill_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			fill_q <= fill_q + 3'(do_push) - 3'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end
endmodule

[hdl/lst_engine.sv]
// Back part: tree walker with node sum and pending add memories.
// Depends on lst_pkg; sweeps both memories to zero after reset.
module lst_engine (
	input  logic          clk,
	input  logic          arst_n,
	output logic          clearing,
	input  logic          cmd_valid,
	input  lst_pkg::cmd_t cmd,
	output logic          cmd_ready,
	output logic          res_valid,
	output lst_pkg::rsp_t res,
	input  logic          res_ready
);
	import lst_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_IDLE  = 11'b00000000010,
		ST_RD    = 11'b00000000100,
		ST_MUL   = 11'b00000001000,
		ST_WR    = 11'b00000010000,
		ST_C0    = 11'b00000100000,
		ST_C1    = 11'b00001000000,
		ST_C2    = 11'b00010000000,
		ST_DEC   = 11'b00100000000,
		ST_LOADW = 11'b01000000000,
		ST_RET   = 11'b10000000000
	} state_t;

	state_t            state_q;
	logic              done_q;
	cmd_t              cmd_q;
	logic [NODE_W-1:0] node_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic              rep_q;
	logic [31:0]       s_q;
	logic [31:0]       p_q;
	logic [31:0]       prod_q;
	logic [31:0]       ret_q;
	logic [31:0]       acc_q;
	logic [NODE_W-1:0] clr_q;
	frame_t            stk_q [STK_DEPTH];
	logic [SP_W-1:0]   sp_q;

	logic [31:0] sum_mem [NODE_COUNT];
	logic [31:0] pend_mem [NODE_COUNT];
	logic [31:0] sum_rd_q;
	logic [31:0] pend_rd_q;

	logic              rd_en;
	logic [NODE_W-1:0] raddr;
	logic [NODE_W-1:0] waddr;
	logic              sum_we;
	logic              pend_we;
	logic [31:0]       sum_wdata;
	logic [31:0]       pend_wdata;

	logic [CNT_W-1:0]  mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [CNT_W-1:0]  span;
	logic [31:0]       new_sum;
	logic [NODE_W-1:0] child0;
	logic [NODE_W-1:0] child1;
	frame_t            top;
	logic [CNT_W-1:0]  tmid_sum;
	logic [IDX_W-1:0]  tmid;
	logic [31:0]       tot;
	logic              outside;
	logic              covered;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W-1:1];
	assign span = {1'b0, hi_q} - {1'b0, lo_q} + 11'd1;
	assign new_sum = s_q + prod_q;
	assign child0 = {node_q[NODE_W-2:0], 1'b0};
	assign child1 = {node_q[NODE_W-2:0], 1'b1};
	assign top = stk_q[sp_q - 4'd1];
	assign tmid_sum = {1'b0, top.lo} + {1'b0, top.hi};
	assign tmid = tmid_sum[CNT_W-1:1];
	assign tot = top.sum_l + ret_q;
	assign outside = (cmd_q.t < lo_q) || (cmd_q.f > hi_q);
	assign covered = (cmd_q.f <= lo_q) && (hi_q <= cmd_q.t);

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_ready = (state_q == ST_IDLE) && !done_q;
	assign res_valid = done_q;
	assign res.range_sum = (cmd_q.kind == K_SUM) ? acc_q : 32'd0;
	assign res.range_error = (cmd_q.kind == K_ERR);

	always_comb begin
		rd_en = 1'b0;
		raddr = node_q;
		waddr = node_q;
		sum_we = 1'b0;
		pend_we = 1'b0;
		sum_wdata = new_sum;
		pend_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				waddr = clr_q;
				sum_we = 1'b1;
				pend_we = 1'b1;
				sum_wdata = '0;
			end
			ST_RD: rd_en = 1'b1;
			ST_WR: begin
				sum_we = 1'b1;
				pend_we = 1'b1;
			end
			ST_C0: begin
				rd_en = 1'b1;
				raddr = child0;
			end
			ST_C1: begin
				rd_en = 1'b1;
				raddr = child1;
				waddr = child0;
				pend_we = 1'b1;
				pend_wdata = pend_rd_q + p_q;
			end
			ST_C2: begin
				waddr = child1;
				pend_we = 1'b1;
				pend_wdata = pend_rd_q + p_q;
			end
			ST_LOADW: begin
				sum_we = 1'b1;
				pend_we = 1'b1;
				sum_wdata = cmd_q.v;
			end
			ST_RET: begin
				waddr = top.node;
				sum_wdata = tot;
				sum_we = (sp_q != '0) && top.phase && (cmd_q.kind != K_SUM);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[waddr] <= sum_wdata;
		end
		if (pend_we) begin
			pend_mem[waddr] <= pend_wdata;
		end
		if (rd_en) begin
			sum_rd_q <= sum_mem[raddr];
			pend_rd_q <= pend_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q <= 1'b0;
			clr_q <= '0;
			sp_q <= '0;
			rep_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 11'd1;
					if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (done_q) begin
						if (res_ready) begin
							done_q <= 1'b0;
						end
					end else if (cmd_valid) begin
						sp_q <= '0;
						rep_q <= 1'b0;
						if (cmd.kind == K_ERR) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WR;
				ST_WR: begin
					if (p_q != '0 && lo_q != hi_q) begin
						state_q <= ST_C0;
					end else begin
						state_q <= ST_DEC;
					end
				end
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_DEC;
				ST_DEC: begin
					if (rep_q || outside) begin
						state_q <= ST_RET;
					end else if (covered) begin
						case (cmd_q.kind)
							K_LOAD: state_q <= ST_LOADW;
							K_ADD: begin
								rep_q <= 1'b1;
								state_q <= ST_MUL;
							end
							default: state_q <= ST_RET;
						endcase
					end else begin
						// descend into the left child
						sp_q <= sp_q + 4'd1;
						state_q <= ST_RD;
					end
				end
				ST_LOADW: state_q <= ST_RET;
				ST_RET: begin
					rep_q <= 1'b0;
					if (sp_q == '0) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end else if (!top.phase) begin
						state_q <= ST_RD;
					end else begin
						sp_q <= sp_q - 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!done_q && cmd_valid) begin
					cmd_q <= cmd;
					node_q <= NODE_W'(1);
					lo_q <= '0;
					hi_q <= cmd.last;
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				if (rep_q) begin
					prod_q <= 32'({21'd0, span} * p_q);
				end else begin
					s_q <= sum_rd_q;
					p_q <= pend_rd_q;
					prod_q <= 32'({21'd0, span} * pend_rd_q);
				end
			end
			ST_WR: s_q <= new_sum;
			ST_DEC: begin
				if (rep_q || outside) begin
					ret_q <= s_q;
				end else if (covered) begin
					case (cmd_q.kind)
						K_ADD: p_q <= cmd_q.v;
						K_SUM: begin
							acc_q <= acc_q + s_q;
							ret_q <= s_q;
						end
						default: ret_q <= s_q;
					endcase
				end else begin
					stk_q[sp_q] <= '{node: node_q, lo: lo_q, hi: hi_q, phase: 1'b0,
						sum_l: 32'd0};
					node_q <= child0;
					hi_q <= mid;
				end
			end
			ST_LOADW: ret_q <= cmd_q.v;
			ST_RET: begin
				if (sp_q != '0) begin
					if (!top.phase) begin
						stk_q[sp_q - 4'd1].phase <= 1'b1;
						stk_q[sp_q - 4'd1].sum_l <= ret_q;
						node_q <= {top.node[NODE_W-2:0], 1'b1};
						lo_q <= tmid + 10'd1;
						hi_q <= top.hi;
					end else begin
						ret_q <= tot;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

[hdl/lst_out_q.sv]
// Result queue between the tree walker and the result ports.
// Depends on lst_pkg.
module lst_out_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  lst_pkg::rsp_t res,
	output logic          res_ready,
	output logic          empty,
	input  logic          pop,
	output lst_pkg::rsp_t rsp
);
	import lst_pkg::*;

	rsp_t       q_q [2];
	logic [1:0] fill_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       do_push;
	logic       do_pop;

	assign res_ready = (fill_q != 2'd2);
	assign empty = (fill_q == 2'd0);
	assign do_push = res_valid && res_ready;
	assign do_pop = pop && !empty;
	assign rsp = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= res;
		end
	end
endmodule

[hdl/lazy_segment_tree_range_add_sum_unit.sv]
// Top level of the lazy segment tree range add/sum unit.
// Depends on lst_pkg, lst_front, lst_engine, lst_out_q and the defines header.
//
// channel   direction  handshake           payload
// request   in         push / full         req (lst_pkg::req_t)
// result    out        pop / empty         rsp (lst_pkg::rsp_t)
// config    in         cfg_we              cfg_wdata (element_count)
//
// After reset the walker zeroes both node memories, all 2048 entries, with full held high.
// A request visits every node on about two root-to-leaf paths; each visit steps through read,
// multiply, write and decide, and first hands a pending add to the children of an inner node
// (read-modify-write on the memory port), plus a return step per node.
// A rejected request skips the tree walk. Up to four requests queue ahead of the walker
// and two results behind it, so each side stalls on its own.
module lazy_segment_tree_range_add_sum_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  lst_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output lst_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [10:0]   cfg_wdata
);
	import lst_pkg::*;
`include "lazy_segment_tree_range_add_sum_unit_defines.svh"

	logic clearing;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	rsp_t res;

	lst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.hold      (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	lst_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	lst_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	`LST_ASSERT_IMP(a_clear_blocks_input, clearing, full, "request accepted during clear")
	`LST_ASSERT_IMP(a_clear_no_result, clearing, empty && !cmd_valid, "activity during clear")
	`LST_ASSERT_NXT(a_result_lands, res_valid && res_ready, !empty, "result lost")
endmodule
